FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds define SYNTH so that
// every use collapses to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check, switched off while the synchronous active-low reset is low.
`define KSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check that also holds through reset.
`define KSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KSD_ASSERT(lbl, clk, rstn, prop, msg)
`define KSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/ksd_pkg.sv
`timescale 1ns / 1ps

package ksd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_UP_ARROW    = 2'd0;
    localparam logic [1:0] REG_DOWN_ARROW  = 2'd1;
    localparam logic [1:0] REG_LEFT_ARROW  = 2'd2;
    localparam logic [1:0] REG_RIGHT_ARROW = 2'd3;

    localparam logic [7:0] UP_ARROW_RESET    = 8'd128;
    localparam logic [7:0] DOWN_ARROW_RESET  = 8'd129;
    localparam logic [7:0] LEFT_ARROW_RESET  = 8'd130;
    localparam logic [7:0] RIGHT_ARROW_RESET = 8'd131;

    // Set-1 scan codes of interest.
    localparam logic [7:0] SC_PREFIX_EXT = 8'hE0;
    localparam logic [7:0] SC_UP         = 8'h48;
    localparam logic [7:0] SC_DOWN       = 8'h50;
    localparam logic [7:0] SC_LEFT       = 8'h4B;
    localparam logic [7:0] SC_RIGHT      = 8'h4D;
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_UP  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_UP  = 8'hB6;
    localparam logic [7:0] SC_TABLE_LEN  = 8'd58;

    // Translation tables, padded to 64 entries with zeros.
    localparam logic [7:0] PLAIN_TAB [0:63] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFTED_TAB [0:63] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [7:0] up;
        logic [7:0] down;
        logic [7:0] left;
        logic [7:0] right;
    } arrow_codes_t;

    // Outcome of decoding one scan byte.
    typedef struct packed {
        logic       push;
        logic [7:0] key;
        logic       ext_next;
        logic       shift_next;
    } decode_t;

endpackage

FILE: hdl/keyboard_scancode_decoder_fifo_unit.sv
`timescale 1ns / 1ps

// Set-1 keyboard scan code decoder with a key queue. Each input transaction
// carries either a raw scan byte (s_tuser low) or a read request (s_tuser
// high); every input transaction produces exactly one registered output
// transaction. Scan bytes track the shift keys and the E0 prefix, translate
// make codes through the plain or shifted ASCII table, and queue the result;
// after E0 the four arrow keys queue the bytes held in the configuration
// registers. A read pops the oldest key, or answers zero with key_valid low
// when the queue is empty. A key that finds the queue full is discarded and
// key_dropped is raised. The queue holds QUEUE_DEPTH-1 keys in one RAM with
// a registered read port; the sustained rate is one transaction per cycle,
// set by that single RAM access per item, and s_tready drops only while a
// result is waiting and m_tready is low. No clearing pass is needed after
// reset: only written entries are ever popped.

`include "assert_macros.svh"

module keyboard_scancode_decoder_fifo_unit #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] scan_byte
    input  logic       s_tuser,   // [0] action: 0 scan byte, 1 read

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] key_char
    output logic [1:0] m_tuser,   // [0] key_valid, [1] key_dropped

    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    // Queue pointers; the queue is empty when they match.
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;

    logic shift_reg, ext_reg;
    ksd_pkg::arrow_codes_t arrows_reg;

    // Output register: flags are held here, the key byte comes from the RAM
    // read register, which only loads on a pop and so holds through a stall.
    logic m_valid_reg;
    logic key_valid_reg;
    logic key_dropped_reg;

    logic [7:0]       ram_rdata;
    ksd_pkg::decode_t dec;

    logic s_acc, is_read, q_empty, q_full;
    logic pop_go, push_go, drop_go, scan_go;

    ksd_decode u_decode (
        .scan_byte   (s_tdata),
        .ext_pending (ext_reg),
        .shift_held  (shift_reg),
        .arrows      (arrows_reg),
        .dec         (dec)
    );

    ksd_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (push_go),
        .waddr (wr_ptr_reg),
        .wdata (dec.key),
        .re    (pop_go),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // A new transaction is taken whenever the output slot is free or being
    // emptied in this cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign is_read  = s_tuser;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_W'(1);
    assign q_empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_full  = (wr_ptr_inc == rd_ptr_reg);

    // A push and a pop never share a cycle, so the RAM sees no same-address
    // collision; a key written in one cycle can be popped in the next.
    assign scan_go = s_acc && !is_read;
    assign pop_go  = s_acc && is_read && !q_empty;
    assign push_go = scan_go && dec.push && !q_full;
    assign drop_go = scan_go && dec.push && q_full;

    assign wr_ptr_next = push_go ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = pop_go ? rd_ptr_inc : rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            shift_reg       <= 1'b0;
            ext_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
            key_valid_reg   <= 1'b0;
            key_dropped_reg <= 1'b0;
            arrows_reg.up    <= ksd_pkg::UP_ARROW_RESET;
            arrows_reg.down  <= ksd_pkg::DOWN_ARROW_RESET;
            arrows_reg.left  <= ksd_pkg::LEFT_ARROW_RESET;
            arrows_reg.right <= ksd_pkg::RIGHT_ARROW_RESET;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (scan_go) begin
                shift_reg <= dec.shift_next;
                ext_reg   <= dec.ext_next;
            end
            if (s_acc) begin
                m_valid_reg     <= 1'b1;
                key_valid_reg   <= pop_go;
                key_dropped_reg <= drop_go;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    ksd_pkg::REG_UP_ARROW:    arrows_reg.up    <= cfg_data;
                    ksd_pkg::REG_DOWN_ARROW:  arrows_reg.down  <= cfg_data;
                    ksd_pkg::REG_LEFT_ARROW:  arrows_reg.left  <= cfg_data;
                    ksd_pkg::REG_RIGHT_ARROW: arrows_reg.right <= cfg_data;
                    default:                  arrows_reg       <= arrows_reg;
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = key_valid_reg ? ram_rdata : 8'h00;
    assign m_tuser  = {key_dropped_reg, key_valid_reg};

    // A read result and a dropped key never come from the same transaction.
    `KSD_ASSERT(a_flags_exclusive, aclk, aresetn,
                m_tvalid |-> !(m_tuser[0] && m_tuser[1]),
                "key_valid and key_dropped raised together")
    // Without a popped key the character must read as zero.
    `KSD_ASSERT(a_char_zero_unless_valid, aclk, aresetn,
                (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00),
                "nonzero key_char without key_valid")
    // A stored key leaves the queue non-empty.
    `KSD_ASSERT(a_push_not_empty, aclk, aresetn,
                push_go |=> (wr_ptr_reg != rd_ptr_reg),
                "queue empty right after a push")
    // A decoded key meeting a full queue is reported as dropped.
    `KSD_ASSERT(a_full_reports_drop, aclk, aresetn,
                (scan_go && dec.push && q_full) |=> (m_tvalid && m_tuser[1]),
                "key lost on a full queue without key_dropped")
    // A pop never happens together with a push; pop_go itself excludes a pop on an empty queue.
    `KSD_ASSERT_ALWAYS(a_single_ram_access, aclk,
                       !(pop_go && push_go),
                       "push and pop in the same cycle")

endmodule

FILE: hdl/ksd_ram.sv
`timescale 1ns / 1ps

module ksd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ksd_decode.sv
`timescale 1ns / 1ps

module ksd_decode (
    input  logic [7:0]            scan_byte,
    input  logic                  ext_pending,
    input  logic                  shift_held,
    input  ksd_pkg::arrow_codes_t arrows,
    output ksd_pkg::decode_t      dec
);

    always_comb begin
        dec.push       = 1'b0;
        dec.key        = 8'h00;
        dec.ext_next   = ext_pending;
        dec.shift_next = shift_held;
        if (scan_byte == ksd_pkg::SC_PREFIX_EXT) begin
            dec.ext_next = 1'b1;
        end else if (ext_pending) begin
            // Anything but a further E0 after the prefix is consumed; only arrows produce a key.
            dec.ext_next = 1'b0;
            case (scan_byte)
                ksd_pkg::SC_UP: begin
                    dec.push = 1'b1;
                    dec.key  = arrows.up;
                end
                ksd_pkg::SC_DOWN: begin
                    dec.push = 1'b1;
                    dec.key  = arrows.down;
                end
                ksd_pkg::SC_LEFT: begin
                    dec.push = 1'b1;
                    dec.key  = arrows.left;
                end
                ksd_pkg::SC_RIGHT: begin
                    dec.push = 1'b1;
                    dec.key  = arrows.right;
                end
                default: begin
                    dec.push = 1'b0;
                end
            endcase
        end else if (scan_byte inside {ksd_pkg::SC_LSHIFT, ksd_pkg::SC_RSHIFT}) begin
            dec.shift_next = 1'b1;
        end else if (scan_byte inside {ksd_pkg::SC_LSHIFT_UP, ksd_pkg::SC_RSHIFT_UP}) begin
            dec.shift_next = 1'b0;
        end else if (scan_byte < ksd_pkg::SC_TABLE_LEN) begin
            dec.key  = shift_held ? ksd_pkg::SHIFTED_TAB[scan_byte[5:0]]
                                  : ksd_pkg::PLAIN_TAB[scan_byte[5:0]];
            dec.push = (dec.key != 8'h00);
        end
    end

endmodule
